>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define RMTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmth assertion failed");
// Checked on every clock edge, reset included.
`define RMTH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rmth assertion failed");
`else
`define RMTH_ASSERT(lbl, prop)
`define RMTH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/rmth_pkg.sv
package rmth_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned HalfCap = Capacity / 2;
  localparam int unsigned AddrW = $clog2(HalfCap);
  localparam int unsigned CountW = AddrW + 1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CountW-1:0] count_t;

  // One heap operation handed to the sift engine.
  typedef struct packed {
    logic    is_pop;
    logic    is_max;
    sample_t value;
    count_t  count;
  } heap_cmd_t;

  // Single-port memory access issued by the sift engine.
  typedef struct packed {
    logic    en;
    logic    we;
    addr_t   addr;
    sample_t wdata;
  } mem_req_t;

  // True when a belongs above b: max-heap if is_max, else min-heap.
  function automatic logic above(sample_t a, sample_t b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

>>> rtl/rmth_ram.sv
module rmth_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

>>> rtl/rmth_sift.sv
module rmth_sift (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  rmth_pkg::heap_cmd_t cmd_i,
  input  rmth_pkg::sample_t  rdata_i,
  output rmth_pkg::mem_req_t mem_o,
  output logic               done_o
);

  typedef enum logic [6:0] {
    E_IDLE   = 7'b0000001,
    E_UP_RD  = 7'b0000010,
    E_UP_CMP = 7'b0000100,
    E_PO_GET = 7'b0001000,
    E_DN_RD  = 7'b0010000,
    E_DN_RDR = 7'b0100000,
    E_DN_CMP = 7'b1000000
  } eng_state_e;

  eng_state_e         state_q, state_d;
  rmth_pkg::addr_t    idx_q, idx_d;
  rmth_pkg::count_t   n_q, n_d;
  rmth_pkg::sample_t  val_q, val_d;
  rmth_pkg::sample_t  left_q, left_d;
  logic               is_max_q, is_max_d;

  rmth_pkg::count_t   child_l;
  rmth_pkg::count_t   child_r;
  rmth_pkg::addr_t    parent;
  rmth_pkg::sample_t  best;
  rmth_pkg::addr_t    best_idx;
  logic               use_right;

  assign child_l = {idx_q, 1'b1};
  assign child_r = child_l + rmth_pkg::count_t'(1);
  assign parent  = (idx_q - rmth_pkg::addr_t'(1)) >> 1;
  assign use_right = (child_r < n_q) && rmth_pkg::above(rdata_i, left_q, is_max_q);
  assign best      = use_right ? rdata_i : left_q;
  assign best_idx  = use_right ? child_r[rmth_pkg::AddrW-1:0]
                               : child_l[rmth_pkg::AddrW-1:0];

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    n_d      = n_q;
    val_d    = val_q;
    left_d   = left_q;
    is_max_d = is_max_q;
    mem_o    = '0;
    done_o   = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (cmd_valid_i) begin
          is_max_d = cmd_i.is_max;
          val_d    = cmd_i.value;
          if (cmd_i.is_pop) begin
            n_d = cmd_i.count - rmth_pkg::count_t'(1);
            if (n_d == '0) begin
              done_o = 1'b1;
            end else begin
              mem_o.en   = 1'b1;
              mem_o.addr = n_d[rmth_pkg::AddrW-1:0];
              state_d    = E_PO_GET;
            end
          end else begin
            idx_d   = cmd_i.count[rmth_pkg::AddrW-1:0];
            state_d = E_UP_RD;
          end
        end
      end
      E_UP_RD: begin
        mem_o.en = 1'b1;
        if (idx_q == '0) begin
          mem_o.we    = 1'b1;
          mem_o.addr  = '0;
          mem_o.wdata = val_q;
          done_o      = 1'b1;
          state_d     = E_IDLE;
        end else begin
          mem_o.addr = parent;
          state_d    = E_UP_CMP;
        end
      end
      E_UP_CMP: begin
        mem_o.en   = 1'b1;
        mem_o.we   = 1'b1;
        mem_o.addr = idx_q;
        if (rmth_pkg::above(val_q, rdata_i, is_max_q)) begin
          mem_o.wdata = rdata_i;
          idx_d       = parent;
          state_d     = E_UP_RD;
        end else begin
          mem_o.wdata = val_q;
          done_o      = 1'b1;
          state_d     = E_IDLE;
        end
      end
      E_PO_GET: begin
        val_d   = rdata_i;
        idx_d   = '0;
        state_d = E_DN_RD;
      end
      E_DN_RD: begin
        mem_o.en = 1'b1;
        if (child_l >= n_q) begin
          mem_o.we    = 1'b1;
          mem_o.addr  = idx_q;
          mem_o.wdata = val_q;
          done_o      = 1'b1;
          state_d     = E_IDLE;
        end else begin
          mem_o.addr = child_l[rmth_pkg::AddrW-1:0];
          state_d    = E_DN_RDR;
        end
      end
      E_DN_RDR: begin
        // The right child may lie past the end; it is then ignored.
        left_d     = rdata_i;
        mem_o.en   = 1'b1;
        mem_o.addr = child_r[rmth_pkg::AddrW-1:0];
        state_d    = E_DN_CMP;
      end
      E_DN_CMP: begin
        mem_o.en   = 1'b1;
        mem_o.we   = 1'b1;
        mem_o.addr = idx_q;
        if (rmth_pkg::above(best, val_q, is_max_q)) begin
          mem_o.wdata = best;
          idx_d       = best_idx;
          state_d     = E_DN_RD;
        end else begin
          mem_o.wdata = val_q;
          done_o      = 1'b1;
          state_d     = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    n_q      <= n_d;
    val_q    <= val_d;
    left_q   <= left_d;
    is_max_q <= is_max_d;
  end

endmodule

>>> rtl/running_median_two_heaps.sv
// Running median over a stream of signed 16-bit samples.
// Input words arrive on the s_axis channel: tdata carries the sample, tlast
// marks the last sample of a stream. Each word yields exactly one output word
// on m_axis: tdata is the median of all samples of the current stream, tuser
// flags a sample dropped because 1024 samples are already stored.
// The lower half lives in a max-heap and the upper half in a min-heap, each a
// 512-entry single-port RAM. An item does at most one pop and two pushes. A push
// sifts up through at most nine levels, reading the parent, then comparing and
// writing; a pop sifts down, reading the left child, then the right child, then
// comparing and writing. A word that finds storage full skips the heaps. The
// single RAM port per heap and the sift loop set how long a word holds the block.
// One word is processed at a time; the next word is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, a finished result waits until the output register
// frees up. Reset empties both heaps and sets the median to zero; the same
// happens after the result of a word carrying tlast. Heap RAMs need no clearing.
`include "assert_macros.svh"

module running_median_two_heaps (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] sample
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] median
  output logic [0:0]  m_axis_tuser_o   // [0] overflow
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_POP   = 5'b00010,
    T_PUSHT = 5'b00100,
    T_PUSHS = 5'b01000,
    T_FIN   = 5'b10000
  } top_state_e;

  top_state_e          state_q, state_d;
  rmth_pkg::count_t    lower_cnt_q, lower_cnt_d;
  rmth_pkg::count_t    upper_cnt_q, upper_cnt_d;
  rmth_pkg::sample_t   median_q, median_d;
  rmth_pkg::sample_t   lower_top_q, upper_top_q;
  rmth_pkg::sample_t   sample_q, moved_q;
  logic                gt_q, mid_q, ovf_q, last_q;
  logic                busy_q;
  logic                out_valid_q;
  rmth_pkg::sample_t   out_median_q;
  logic                out_ovf_q;

  rmth_pkg::heap_cmd_t cmd;
  logic                cmd_fire;
  logic                eng_done;
  logic                cur_sel;  // 1: upper heap
  rmth_pkg::mem_req_t  mem_req;
  rmth_pkg::sample_t   lower_rdata, upper_rdata;
  logic                in_fire;
  logic                out_load;
  rmth_pkg::sample_t   in_sample;
  logic                in_gt;
  logic                in_full;
  logic                cnt_eq;
  logic signed [rmth_pkg::SampleW:0] top_sum;
  logic signed [rmth_pkg::SampleW:0] top_adj;
  rmth_pkg::sample_t   new_median;

  assign s_axis_tready_o = (state_q == T_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_sample = rmth_pkg::sample_t'(s_axis_tdata_i);
  assign in_gt     = in_sample > median_q;
  assign in_full   = ({1'b0, lower_cnt_q} + {1'b0, upper_cnt_q})
                     >= (rmth_pkg::CountW + 1)'(rmth_pkg::Capacity);
  assign cnt_eq    = (lower_cnt_q == upper_cnt_q);

  // The pop and the final push both act on the side the sample falls on.
  always_comb begin
    cur_sel = gt_q;
    if (state_q == T_PUSHT) begin
      cur_sel = !gt_q;
    end
  end

  assign cmd_fire    = (state_q == T_POP || state_q == T_PUSHT || state_q == T_PUSHS)
                       && !busy_q;
  assign cmd.is_pop  = (state_q == T_POP);
  assign cmd.is_max  = !cur_sel;
  assign cmd.value   = (state_q == T_PUSHT) ? moved_q : sample_q;
  assign cmd.count   = cur_sel ? upper_cnt_q : lower_cnt_q;

  rmth_sift u_sift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_fire),
    .cmd_i       (cmd),
    .rdata_i     (cur_sel ? upper_rdata : lower_rdata),
    .mem_o       (mem_req),
    .done_o      (eng_done)
  );

  rmth_ram #(.Width(rmth_pkg::SampleW), .Depth(rmth_pkg::HalfCap)) u_lower_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en && !cur_sel),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (lower_rdata)
  );

  rmth_ram #(.Width(rmth_pkg::SampleW), .Depth(rmth_pkg::HalfCap)) u_upper_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en && cur_sel),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (upper_rdata)
  );

  // Mean of the two tops, rounded toward zero.
  assign top_sum = {lower_top_q[rmth_pkg::SampleW-1], lower_top_q}
                 + {upper_top_q[rmth_pkg::SampleW-1], upper_top_q};
  assign top_adj = top_sum + {{rmth_pkg::SampleW{1'b0}}, top_sum[rmth_pkg::SampleW]};

  always_comb begin
    if (ovf_q) begin
      new_median = median_q;
    end else if (mid_q) begin
      new_median = top_adj[rmth_pkg::SampleW:1];
    end else begin
      new_median = gt_q ? upper_top_q : lower_top_q;
    end
  end

  assign out_load = (state_q == T_FIN) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    lower_cnt_d = lower_cnt_q;
    upper_cnt_d = upper_cnt_q;
    median_d    = median_q;
    if (cmd_fire) begin
      if (cur_sel) begin
        upper_cnt_d = cmd.is_pop ? upper_cnt_q - rmth_pkg::count_t'(1)
                                 : upper_cnt_q + rmth_pkg::count_t'(1);
      end else begin
        lower_cnt_d = cmd.is_pop ? lower_cnt_q - rmth_pkg::count_t'(1)
                                 : lower_cnt_q + rmth_pkg::count_t'(1);
      end
    end
    unique case (state_q)
      T_IDLE: begin
        if (in_fire) begin
          if (in_full) begin
            state_d = T_FIN;
          end else if (!cnt_eq && (in_gt == (upper_cnt_q > lower_cnt_q))) begin
            state_d = T_POP;
          end else begin
            state_d = T_PUSHS;
          end
        end
      end
      T_POP:   if (eng_done) state_d = T_PUSHT;
      T_PUSHT: if (eng_done) state_d = T_PUSHS;
      T_PUSHS: if (eng_done) state_d = T_FIN;
      T_FIN: begin
        if (out_load) begin
          state_d  = T_IDLE;
          median_d = new_median;
          if (last_q) begin
            lower_cnt_d = '0;
            upper_cnt_d = '0;
            median_d    = '0;
          end
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      lower_cnt_q <= '0;
      upper_cnt_q <= '0;
      median_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lower_cnt_q <= lower_cnt_d;
      upper_cnt_q <= upper_cnt_d;
      median_q    <= median_d;
      busy_q      <= (busy_q || cmd_fire) && !eng_done;
      out_valid_q <= (out_valid_q && !m_axis_tready_i) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_sample;
      gt_q     <= in_gt;
      mid_q    <= !cnt_eq;
      ovf_q    <= in_full;
      last_q   <= s_axis_tlast_i;
      // Top of the heap that gives up an element, should a pop follow.
      moved_q  <= in_gt ? upper_top_q : lower_top_q;
    end
    // Shadow copies of both roots follow every write to entry zero.
    if (mem_req.en && mem_req.we && mem_req.addr == '0) begin
      if (cur_sel) begin
        upper_top_q <= mem_req.wdata;
      end else begin
        lower_top_q <= mem_req.wdata;
      end
    end
    if (out_load) begin
      out_median_q <= new_median;
      out_ovf_q    <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_median_q;
  assign m_axis_tuser_o  = out_ovf_q;

  `RMTH_ASSERT(a_balanced, (state_q == T_IDLE) |-> (lower_cnt_q == upper_cnt_q || lower_cnt_q == upper_cnt_q + rmth_pkg::count_t'(1) || upper_cnt_q == lower_cnt_q + rmth_pkg::count_t'(1)))
  `RMTH_ASSERT(a_capacity, (lower_cnt_q <= rmth_pkg::count_t'(rmth_pkg::HalfCap)) && (upper_cnt_q <= rmth_pkg::count_t'(rmth_pkg::HalfCap)))
  `RMTH_ASSERT(a_done_owned, eng_done |-> (busy_q || cmd_fire))
  `RMTH_ASSERT(a_one_result, out_load |=> (state_q == T_IDLE && m_axis_tvalid_o))

endmodule

>>> tb/sv/tb_running_median_two_heaps.sv
module tb_running_median_two_heaps;

  localparam int WatchLimit = 5000;
  localparam int LongHold   = 400;

  typedef struct packed {
    rmth_pkg::sample_t median;
    logic              overflow;
  } median_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;  // [15:0] sample
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;  // [15:0] median
  logic [0:0]  m_axis_tuser_o;  // [0] overflow

  // Heap 0 holds the lower half as a max-heap, heap 1 the upper half as a min-heap.
  int heap_mem [2][rmth_pkg::HalfCap];
  int heap_cnt [2];
  int run_median;

  median_word_t pending_medians[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  tx_quiet;
  bit  rx_quiet;
  // Each increment asks the receiver for one long hold.
  int  rx_hold = 0;

  running_median_two_heaps u_top (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit ranks_above(int a, int b, int side);
    return (side == 0) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(int side, int v);
    int i;
    int p;
    i = heap_cnt[side];
    heap_cnt[side] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(v, heap_mem[side][p], side)) break;
      heap_mem[side][i] = heap_mem[side][p];
      i = p;
    end
    heap_mem[side][i] = v;
  endfunction

  function automatic int heap_take_top(int side);
    int top;
    int n;
    int i;
    int c;
    int v;
    top = heap_mem[side][0];
    n = heap_cnt[side] - 1;
    heap_cnt[side] = n;
    if (n > 0) begin
      v = heap_mem[side][n];
      i = 0;
      forever begin
        c = 2 * i + 1;
        if (c >= n) break;
        if (c + 1 < n && ranks_above(heap_mem[side][c + 1], heap_mem[side][c], side))
          c = c + 1;
        if (!ranks_above(heap_mem[side][c], v, side)) break;
        heap_mem[side][i] = heap_mem[side][c];
        i = c;
      end
      heap_mem[side][i] = v;
    end
    return top;
  endfunction

  function automatic median_word_t next_median(rmth_pkg::sample_t smp, logic last);
    median_word_t res;
    int s;
    s = smp;
    res.overflow = 1'b0;
    if (heap_cnt[0] + heap_cnt[1] >= 2 * rmth_pkg::HalfCap) begin
      res.overflow = 1'b1;
    end else if (heap_cnt[0] == heap_cnt[1]) begin
      if (s > run_median) begin
        heap_insert(1, s);
        run_median = heap_mem[1][0];
      end else begin
        heap_insert(0, s);
        run_median = heap_mem[0][0];
      end
    end else begin
      if (heap_cnt[0] > heap_cnt[1]) begin
        if (s > run_median) begin
          heap_insert(1, s);
        end else begin
          heap_insert(1, heap_take_top(0));
          heap_insert(0, s);
        end
      end else begin
        if (s > run_median) begin
          heap_insert(0, heap_take_top(1));
          heap_insert(1, s);
        end else begin
          heap_insert(0, s);
        end
      end
      // Integer division truncates toward zero, as the block does.
      run_median = (heap_mem[0][0] + heap_mem[1][0]) / 2;
    end
    res.median = rmth_pkg::sample_t'(run_median);
    if (last) begin
      heap_cnt[0] = 0;
      heap_cnt[1] = 0;
      run_median = 0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_word(rmth_pkg::sample_t smp, logic last);
    int gap;
    median_word_t expected;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected = next_median(smp, last);
    pending_medians = {pending_medians, expected};
  endtask

  function automatic rmth_pkg::sample_t random_sample();
    case ($urandom_range(0, 3))
      0: return rmth_pkg::sample_t'($urandom_range(0, 65535));
      1: return rmth_pkg::sample_t'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return rmth_pkg::sample_t'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold when requested.
  initial begin
    int stall;
    int hold_seen;
    m_axis_tready_i = 1'b0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (rx_hold != hold_seen) begin
        stall = LongHold;
        hold_seen = rx_hold;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected word median", $signed(m_axis_tdata_o), 0);
      end else begin
        median_word_t want;
        want = pending_medians.pop_front();
        if (m_axis_tdata_o !== want.median)
          report_mismatch("median", $signed(m_axis_tdata_o), want.median);
        if (m_axis_tuser_o[0] !== want.overflow)
          report_mismatch("overflow", m_axis_tuser_o[0], want.overflow);
      end
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_extremes();
    rmth_pkg::sample_t vals[$];
    vals = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh7fff, 16'sh8000,
             16'sh8000, 16'sh7fff, 16'sd5, 16'sd5, 16'sd5};
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
    // Single-sample streams, negative and positive first sample, and ties.
    send_word(-16'sd7, 1'b1);
    send_word(16'sd9, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sd0, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(16'sd4, 1'b1);
  endtask

  task automatic test_overflow();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int i = 0; i < 2 * rmth_pkg::HalfCap + 4; i++) send_word(random_sample(), 1'b0);
    send_word(random_sample(), 1'b1);
    // The stream must be empty again after the mark.
    send_word(16'sd123, 1'b0);
    send_word(-16'sd50, 1'b1);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_hold++;
    for (int i = 0; i < 12; i++) send_word(random_sample(), i == 11);
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_streams();
    int sent;
    int len;
    sent = 0;
    while (sent < 80) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 60) : $urandom_range(1, 40);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_word(random_sample(), i == len - 1);
      sent += len;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    heap_cnt[0] = 0;
    heap_cnt[1] = 0;
    run_median = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_overflow();
    test_backpressure();
    test_random_streams();

    s_axis_tvalid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
